@@ rtl/lbe_pkg.sv @@
// lbe_pkg: shared constants for the LZW byte encoder.
// No dependencies; used by the interfaces, the search cell and the top level.
package lbe_pkg;

	// Codes 0..255 are the implicit single-byte strings.
	localparam int BASE_CODES = 256;
	localparam int BYTE_W = 8;
	localparam int OUT_CODE_W = 10;
	localparam int LIMIT_W = 10;
	localparam logic [LIMIT_W-1:0] DICT_LIMIT_RESET = 10'd512;

	// Default dictionary size including the implicit codes.
	localparam int MAX_CODES_DEF = 1024;

	// Search chain: dictionary slot s lives in cell (s % NUM_CELLS), row (s / NUM_CELLS).
	localparam int NUM_CELLS = 16;
	localparam int CELL_W = $clog2(NUM_CELLS);

endpackage

@@ rtl/lbe_if.sv @@
// lbe_if: valid/ready channels of the LZW byte encoder (input bytes, codes, config).
// Depends on lbe_pkg for field widths.
interface lbe_item_if;
	logic                          valid;
	logic                          ready;
	logic [lbe_pkg::BYTE_W-1:0]    data_byte;
	logic                          first_byte;
	logic                          last_byte;

	modport source (output valid, data_byte, first_byte, last_byte, input ready);
	modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface lbe_result_if;
	logic                             valid;
	logic                             ready;
	logic [lbe_pkg::OUT_CODE_W-1:0]   code;
	logic                             last_code;

	modport source (output valid, code, last_code, input ready);
	modport sink (input valid, code, last_code, output ready);
endinterface

interface lbe_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lbe_pkg::LIMIT_W-1:0]   dict_limit;

	modport source (output valid, dict_limit, input ready);
	modport sink (input valid, dict_limit, output ready);
endinterface

@@ rtl/lbe_ram.sv @@
// lbe_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lbe_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/lbe_cell.sv @@
// lbe_cell: one search cell; holds every NUM_CELLS-th dictionary entry in a lbe_ram
// and passes the lookup beat to its neighbor each cycle. Depends on lbe_pkg, lbe_ram.
module lbe_cell #(
	parameter type tok_t = logic,
	parameter int  CELL_IDX = 0,
	parameter int  ROWS = 48,
	parameter int  CODE_W = 10,
	parameter int  ENT_W = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tok_t                                 tok_in,
	output tok_t                                 tok_out,
	input  logic [ENT_W-1:0]                     entries,
	input  logic                                 wr_en,
	input  logic [$clog2(ROWS)-1:0]              wr_row,
	input  logic [CODE_W+lbe_pkg::BYTE_W-1:0]    wr_data
);

	localparam int ROW_W = $clog2(ROWS);
	localparam int SLOT_W = ROW_W + lbe_pkg::CELL_W;
	localparam int CMP_W = (SLOT_W > ENT_W) ? SLOT_W : ENT_W;
	localparam int DATA_W = CODE_W + lbe_pkg::BYTE_W;

	tok_t              tok_s1;
	logic [DATA_W-1:0] rdata;
	logic [SLOT_W-1:0] slot;
	logic              in_range;
	logic              match;

	lbe_ram #(
		.WIDTH (DATA_W),
		.DEPTH (ROWS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_row),
		.wdata (wr_data),
		.raddr (tok_in.row),
		.rdata (rdata)
	);

	// RAM read and beat register advance together, so rdata lines up with tok_s1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_in;
		end
	end

	assign slot = {tok_s1.row, lbe_pkg::CELL_W'(CELL_IDX)};
	assign in_range = CMP_W'(slot) < CMP_W'(entries);
	assign match = tok_s1.valid && !tok_s1.hit && in_range
		&& (rdata == {tok_s1.pfx, tok_s1.chr});

	always_comb begin
		tok_out = tok_s1;
		if (match) begin
			tok_out.hit = 1'b1;
			tok_out.code = CODE_W'(slot) + CODE_W'(lbe_pkg::BASE_CODES);
		end
	end

endmodule

@@ rtl/lzw_byte_encoder.sv @@
// lzw_byte_encoder: top level of the LZW byte encoder; sequencer, output register
// and the chain of lbe_cell search cells. Depends on lbe_pkg, lbe_if, lbe_cell.
//
// Usage:
//   item   - one byte per beat with first_byte / last_byte file marks.
//   result - emitted LZW codes, 0 to 2 per byte; last_code marks a file's flush code.
//   cfg    - writes dict_limit; write it only while the encoder is idle.
// A byte with first_byte set passes from idle through the flush state, with or without
// a flush code. Any other byte is looked up in the dictionary: one row beat enters a
// 16-cell chain per cycle, one row per 16 stored entries, and each beat passes through
// the register of every cell in turn. A hit goes on to the flush state; a miss goes
// through the miss state first. The rows searched follow the entry count, which the
// dictionary size bounds (1024 codes at the default size).
// Results sit in a one-beat output register; the encoder accepts the next byte
// while that register still waits, and holds in place when a new code meets a
// full register that the receiver does not take.
// Reset empties the dictionary (entry count 0), clears the prefix to code 0,
// sets dict_limit to 512 and drops any pending result.
module lzw_byte_encoder #(
	parameter int MAX_CODES = lbe_pkg::MAX_CODES_DEF
) (
	input logic           clk,
	input logic           arst_n,
	lbe_item_if.sink      item,
	lbe_result_if.source  result,
	lbe_cfg_if.sink       cfg
);

	localparam int CODE_W = $clog2(MAX_CODES);
	localparam int ENTRIES = MAX_CODES - lbe_pkg::BASE_CODES;
	localparam int ENT_W = $clog2(ENTRIES + 1);
	localparam int NFC_W = $clog2(MAX_CODES + 1);
	localparam int ROWS = (ENTRIES + lbe_pkg::NUM_CELLS - 1) / lbe_pkg::NUM_CELLS;
	localparam int ROW_W = $clog2(ROWS);
	localparam int RCNT_W = $clog2(ROWS + 1);
	localparam int SLOT_W = ROW_W + lbe_pkg::CELL_W;
	localparam int DATA_W = CODE_W + lbe_pkg::BYTE_W;

	typedef struct packed {
		logic                        valid;
		logic [ROW_W-1:0]            row;
		logic [CODE_W-1:0]           pfx;
		logic [lbe_pkg::BYTE_W-1:0]  chr;
		logic                        hit;
		logic [CODE_W-1:0]           code;
	} tok_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_MISS   = 4'b0100,
		ST_FLUSH  = 4'b1000
	} state_t;

	state_t                          state_q;
	logic [lbe_pkg::BYTE_W-1:0]      byte_q;
	logic                            last_q;
	logic [CODE_W-1:0]               prefix_q;
	logic [ENT_W-1:0]                ent_q;
	logic [lbe_pkg::LIMIT_W-1:0]     limit_q;
	logic [RCNT_W-1:0]               rows_q;
	logic [RCNT_W-1:0]               issue_q;
	logic [RCNT_W-1:0]               rcv_q;
	logic                            hit_q;
	logic [CODE_W-1:0]               hit_code_q;
	logic                            out_valid_q;
	logic [lbe_pkg::OUT_CODE_W-1:0]  out_code_q;
	logic                            out_last_q;

	tok_t                            chain [lbe_pkg::NUM_CELLS+1];
	tok_t                            tail;
	logic                            out_free;
	logic                            out_load;
	logic                            add_ok;
	logic                            dict_wr;
	logic [SLOT_W-1:0]               wr_slot;
	logic [DATA_W-1:0]               wr_data;
	logic [ENT_W:0]                  rows_sum;
	logic [RCNT_W-1:0]               rows_need;
	logic                            search_done;

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign result.valid = out_valid_q;
	assign result.code = out_code_q;
	assign result.last_code = out_last_q;

	assign out_free = !out_valid_q || result.ready;
	assign out_load = out_free
		&& ((state_q == ST_MISS) || ((state_q == ST_FLUSH) && last_q));

	// Rows holding valid entries: ceil(entries / NUM_CELLS).
	assign rows_sum = (ENT_W+1)'(ent_q) + (ENT_W+1)'(lbe_pkg::NUM_CELLS - 1);
	assign rows_need = RCNT_W'(rows_sum >> lbe_pkg::CELL_W);

	// Room in the dictionary and the next free code (entry count + 256) at or below the limit.
	assign add_ok = (NFC_W'(ent_q) + NFC_W'(lbe_pkg::BASE_CODES) <= NFC_W'(limit_q))
		&& (ent_q < ENT_W'(ENTRIES));
	assign dict_wr = (state_q == ST_MISS) && out_free && add_ok;
	assign wr_slot = SLOT_W'(ent_q);
	assign wr_data = {prefix_q, byte_q};

	assign search_done = (state_q == ST_SEARCH) && (rcv_q == rows_q);

	always_comb begin
		chain[0] = '0;
		chain[0].valid = (state_q == ST_SEARCH) && (issue_q < rows_q);
		chain[0].row = ROW_W'(issue_q);
		chain[0].pfx = prefix_q;
		chain[0].chr = byte_q;
	end

	for (genvar k = 0; k < lbe_pkg::NUM_CELLS; k++) begin : g_cell
		lbe_cell #(
			.tok_t    (tok_t),
			.CELL_IDX (k),
			.ROWS     (ROWS),
			.CODE_W   (CODE_W),
			.ENT_W    (ENT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[k]),
			.tok_out (chain[k+1]),
			.entries (ent_q),
			.wr_en   (dict_wr && (wr_slot[lbe_pkg::CELL_W-1:0] == lbe_pkg::CELL_W'(k))),
			.wr_row  (wr_slot[SLOT_W-1:lbe_pkg::CELL_W]),
			.wr_data (wr_data)
		);
	end

	assign tail = chain[lbe_pkg::NUM_CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lbe_pkg::DICT_LIMIT_RESET;
		end else if (cfg.valid) begin
			limit_q <= cfg.dict_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prefix_q <= '0;
			ent_q <= '0;
			rows_q <= '0;
			issue_q <= '0;
			rcv_q <= '0;
			hit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !result.ready);
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						if (item.first_byte) begin
							prefix_q <= CODE_W'(item.data_byte);
							state_q <= ST_FLUSH;
						end else begin
							rows_q <= rows_need;
							state_q <= ST_SEARCH;
						end
						issue_q <= '0;
						rcv_q <= '0;
						hit_q <= 1'b0;
					end
				end
				ST_SEARCH: begin
					if (chain[0].valid) begin
						issue_q <= issue_q + 1'b1;
					end
					if (tail.valid) begin
						rcv_q <= rcv_q + 1'b1;
						// keep the lowest matching code
						if (tail.hit && !hit_q) begin
							hit_q <= 1'b1;
						end
					end
					if (search_done) begin
						if (hit_q) begin
							prefix_q <= hit_code_q;
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_MISS;
						end
					end
				end
				ST_MISS: begin
					if (out_free) begin
						if (add_ok) begin
							ent_q <= ent_q + 1'b1;
						end
						prefix_q <= CODE_W'(byte_q);
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!last_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: no reset.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			byte_q <= item.data_byte;
			last_q <= item.last_byte;
		end
		if ((state_q == ST_SEARCH) && tail.valid && tail.hit && !hit_q) begin
			hit_code_q <= tail.code;
		end
		if ((state_q == ST_MISS) && out_free) begin
			out_code_q <= lbe_pkg::OUT_CODE_W'(prefix_q);
			out_last_q <= 1'b0;
		end else if ((state_q == ST_FLUSH) && last_q && out_free) begin
			out_code_q <= lbe_pkg::OUT_CODE_W'(prefix_q);
			out_last_q <= 1'b1;
		end
	end

endmodule

@@ bench/lzw_byte_encoder_test.sv @@
`timescale 1ns / 100ps
// lzw_byte_encoder_test: self-checking bench for the LZW byte encoder; predicts the
// emitted codes per accepted byte and checks every code beat in order.
// Depends on lbe_pkg, lbe_if and the lzw_byte_encoder RTL.
module lzw_byte_encoder_test;

	localparam int BYTE_W = lbe_pkg::BYTE_W;
	localparam int OUT_CODE_W = lbe_pkg::OUT_CODE_W;
	localparam int LIMIT_W = lbe_pkg::LIMIT_W;
	localparam int BASE_CODES = lbe_pkg::BASE_CODES;
	localparam logic [LIMIT_W-1:0] DICT_LIMIT_RESET = lbe_pkg::DICT_LIMIT_RESET;
	localparam int MAX_CODES = lbe_pkg::MAX_CODES_DEF;
	localparam int DICT_SLOTS = MAX_CODES - BASE_CODES;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE_CYCLES = 120;
	localparam int PRINT_CAP = 30;

	typedef struct {
		logic [BYTE_W-1:0] data_byte;
		logic              first_byte;
		logic              last_byte;
	} byte_beat_t;

	typedef struct {
		logic [OUT_CODE_W-1:0] code;
		logic                  last_code;
	} code_beat_t;

	logic clk;
	logic arst_n;

	lbe_item_if   item_ch ();
	lbe_result_if code_ch ();
	lbe_cfg_if    cfg_ch ();

	lzw_byte_encoder #(.MAX_CODES(MAX_CODES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (code_ch),
		.cfg    (cfg_ch)
	);

	// Encoder shadow state
	int               dict_prefix [DICT_SLOTS];
	logic [BYTE_W-1:0] dict_char [DICT_SLOTS];
	int               free_code = BASE_CODES;
	int               prefix_code = 0;
	logic [LIMIT_W-1:0] limit_reg;

	byte_beat_t byte_q [$];
	code_beat_t code_q [$];

	int  err_count = 0;
	int  cycle_count = 0;
	bit  bursts_on;
	bit  byte_taken;
	int  send_gap;
	int  take_stall;

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	function automatic void predict_codes(input logic [BYTE_W-1:0] b, input logic f,
			input logic l);
		int hit;
		code_beat_t cb;
		if (f) begin
			prefix_code = int'(b);
		end else begin
			hit = -1;
			for (int c = BASE_CODES; c < free_code && c < MAX_CODES; c++) begin
				if (dict_prefix[c - BASE_CODES] == prefix_code &&
						dict_char[c - BASE_CODES] == b) begin
					hit = c;
					break;
				end
			end
			if (hit >= 0) begin
				prefix_code = hit;
			end else begin
				cb.code = prefix_code[OUT_CODE_W-1:0];
				cb.last_code = 1'b0;
				code_q = {code_q, cb};
				if (free_code <= int'(limit_reg) && free_code < MAX_CODES) begin
					dict_prefix[free_code - BASE_CODES] = prefix_code;
					dict_char[free_code - BASE_CODES] = b;
					free_code++;
				end
				prefix_code = int'(b);
			end
		end
		if (l) begin
			cb.code = prefix_code[OUT_CODE_W-1:0];
			cb.last_code = 1'b1;
			code_q = {code_q, cb};
		end
	endfunction

	// Byte driver: hold a beat until taken, insert random gaps between beats.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.data_byte <= '0;
			item_ch.first_byte <= 1'b0;
			item_ch.last_byte <= 1'b0;
			send_gap <= 0;
		end else if (item_ch.valid && !byte_taken) begin
			item_ch.valid <= 1'b1;
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			item_ch.valid <= 1'b0;
		end else if (byte_q.size() != 0) begin
			if (bursts_on && $urandom_range(0, 4) == 0) begin
				send_gap <= $urandom_range(1, 8) - 1;
				item_ch.valid <= 1'b0;
			end else begin
				item_ch.valid <= 1'b1;
				item_ch.data_byte <= byte_q[0].data_byte;
				item_ch.first_byte <= byte_q[0].first_byte;
				item_ch.last_byte <= byte_q[0].last_byte;
				void'(byte_q.pop_front());
			end
		end else begin
			item_ch.valid <= 1'b0;
		end
	end

	// Code receiver backpressure
	always @(negedge clk) begin
		if (!arst_n) begin
			code_ch.ready <= 1'b0;
			take_stall <= 0;
		end else if (take_stall > 0) begin
			take_stall <= take_stall - 1;
			code_ch.ready <= 1'b0;
		end else if (bursts_on && $urandom_range(0, 6) == 0) begin
			take_stall <= $urandom_range(1, 8) - 1;
			code_ch.ready <= 1'b0;
		end else begin
			code_ch.ready <= 1'b1;
		end
	end

	// Monitor: predict on every byte beat, check every code beat.
	always @(posedge clk) begin
		code_beat_t want;
		if (arst_n) begin
			byte_taken <= item_ch.valid && item_ch.ready;
			if (item_ch.valid && item_ch.ready)
				predict_codes(item_ch.data_byte, item_ch.first_byte, item_ch.last_byte);
			if (code_ch.valid && code_ch.ready) begin
				if (code_q.size() == 0) begin
					report_mismatch($sformatf("unexpected code %0d last_code %0b",
						code_ch.code, code_ch.last_code));
				end else begin
					want = code_q.pop_front();
					if (code_ch.code !== want.code || code_ch.last_code !== want.last_code)
						report_mismatch($sformatf("code %0d last_code %0b, want %0d / %0b",
							code_ch.code, code_ch.last_code, want.code, want.last_code));
				end
			end
		end else begin
			byte_taken <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			report_mismatch($sformatf("timeout after %0d cycles", cycle_count));
			$display("lzw_byte_encoder verification failed");
			$finish;
		end
	end

	function automatic void queue_byte(input logic [BYTE_W-1:0] b, input logic f,
			input logic l);
		byte_beat_t bb;
		bb.data_byte = b;
		bb.first_byte = f;
		bb.last_byte = l;
		byte_q = {byte_q, bb};
	endfunction

	// Queue random files: mostly well formed, some with a missing mark.
	task automatic queue_files(input int n_items, input int full_pct);
		int sent;
		int len;
		int kind;
		bit wide;
		logic [BYTE_W-1:0] base;
		logic [BYTE_W-1:0] b;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			kind = $urandom_range(0, 9);
			wide = ($urandom_range(0, 99) < full_pct);
			base = 8'($urandom_range(0, 255));
			for (int i = 0; i < len; i++) begin
				b = wide ? 8'($urandom_range(0, 255)) : (base ^ 8'($urandom_range(0, 3)));
				queue_byte(b, (kind != 8) && (i == 0), (kind != 9) && (i == len - 1));
			end
			sent += len;
		end
	endtask

	task automatic wait_idle();
		while (byte_q.size() != 0 || item_ch.valid || code_q.size() != 0)
			@(posedge clk);
		// cover bytes that emit nothing but are still in the search chain
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.dict_limit <= v;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		limit_reg = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.dict_limit = '0;
		bursts_on = 1'b1;
		limit_reg = DICT_LIMIT_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: lowest limit that still admits one entry
		write_limit(10'd256);
		queue_byte(8'h41, 1'b0, 1'b0);	// continue from reset prefix 0, adds entry 256
		queue_byte(8'h41, 1'b0, 1'b0);	// miss, no room left
		queue_byte(8'h00, 1'b1, 1'b1);	// one-byte file
		queue_byte(8'hFF, 1'b1, 1'b1);
		queue_byte(8'h00, 1'b1, 1'b0);
		queue_byte(8'h41, 1'b0, 1'b1);	// hit on entry 256, flush it
		queue_byte(8'hFF, 1'b1, 1'b0);
		queue_byte(8'h80, 1'b0, 1'b1);	// miss then flush
		queue_byte(8'h7F, 1'b0, 1'b0);	// continue after a last byte
		queue_byte(8'h00, 1'b0, 1'b1);
		queue_byte(8'h55, 1'b1, 1'b0);
		queue_byte(8'hAA, 1'b0, 1'b0);
		queue_byte(8'h55, 1'b0, 1'b0);
		queue_byte(8'hAA, 1'b0, 1'b1);
		wait_idle();

		// Limit below the implicit codes: nothing added
		write_limit(10'd0);
		queue_files(100, 50);
		wait_idle();

		write_limit(10'd400);
		queue_files(300, 40);
		wait_idle();

		write_limit(DICT_LIMIT_RESET);
		queue_files(300, 50);
		wait_idle();

		write_limit(10'($urandom_range(256, 1023)));
		queue_files(250, 60);
		wait_idle();

		// Highest limit: run the dictionary until it is full
		write_limit(10'd1023);
		queue_files(500, 85);
		while (byte_q.size() != 0) @(posedge clk);
		bursts_on = 1'b0;
		queue_files(300, 50);
		wait_idle();

		if (code_q.size() != 0)
			report_mismatch($sformatf("%0d expected codes never came", code_q.size()));
		if (err_count == 0) begin
			$display("lzw_byte_encoder verification clean");
		end else begin
			$display("lzw_byte_encoder verification failed");
		end
		$finish;
	end

endmodule
